/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the block decoder.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bc1_pkg.sv */
// Shared types, constants and widening functions of the BC1 block decoder.
// Used by the expand, palette and serialize stages and by the top level.
package bc1_pkg;

    localparam int ColorW     = 16;
    localparam int ChanW      = 8;
    localparam int NumEntries = 4;
    localparam int PixPerBlock = 16;
    localparam int SelW       = $clog2(NumEntries);
    localparam int PixW       = $clog2(PixPerBlock);
    localparam int IdxW       = PixPerBlock * SelW;
    localparam int PosW       = 2;

    localparam int ChanMax  = 255;
    localparam int Div31Mul   = 8457;
    localparam int Div31Shift = 18;
    localparam int Div63Mul   = 16645;
    localparam int Div63Shift = 20;
    localparam int Div3Mul  = 683;
    localparam int Div3Shift = 11;

    localparam logic [ChanW-1:0] Opaque      = ChanW'(ChanMax);
    localparam logic [ChanW-1:0] Transparent = '0;
    localparam logic [PixW-1:0]  LastPix     = PixW'(PixPerBlock - 1);

    typedef struct packed {
        logic [ChanW-1:0] r;
        logic [ChanW-1:0] g;
        logic [ChanW-1:0] b;
    } t_rgb8;

    typedef struct packed {
        logic [ChanW-1:0] r;
        logic [ChanW-1:0] g;
        logic [ChanW-1:0] b;
        logic [ChanW-1:0] a;
    } t_rgba;

    typedef struct packed {
        t_rgb8           end_a;
        t_rgb8           end_b;
        logic            four_color;
        logic [IdxW-1:0] idx;
    } t_ends;

    typedef struct packed {
        t_rgba [NumEntries-1:0] entry;
        logic [IdxW-1:0]        idx;
    } t_pal;

    // Exact floor of v * 255 / 31 through a reciprocal multiplication.
    function automatic logic [ChanW-1:0] widen5(input logic [4:0] v);
        logic [12:0] p;
        logic [26:0] q;
        begin
            p = 13'(v) * 13'(ChanMax);
            q = 27'(p) * 27'(Div31Mul);
            return ChanW'(q >> Div31Shift);
        end
    endfunction

    // Exact floor of v * 255 / 63 through a reciprocal multiplication.
    function automatic logic [ChanW-1:0] widen6(input logic [5:0] v);
        logic [13:0] p;
        logic [28:0] q;
        begin
            p = 14'(v) * 14'(ChanMax);
            q = 29'(p) * 29'(Div63Mul);
            return ChanW'(q >> Div63Shift);
        end
    endfunction

    // Exact floor of x / 3 for x below 768; larger quotients do not fit the 8-bit result.
    function automatic logic [ChanW-1:0] div3(input logic [9:0] x);
        logic [19:0] p;
        begin
            p = 20'(x) * 20'(Div3Mul);
            return ChanW'(p >> Div3Shift);
        end
    endfunction

    function automatic t_rgb8 unpack565(input logic [ColorW-1:0] c);
        t_rgb8 res;
        begin
            res.r = widen5(c[15:11]);
            res.g = widen6(c[10:5]);
            res.b = widen5(c[4:0]);
            return res;
        end
    endfunction

endpackage

/* rtl/bc1_expand.sv */
// First pipeline stage: widens both RGB565 endpoints to 8-bit channels.
// Depends on bc1_pkg.
module bc1_expand (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bc1_pkg::ColorW-1:0]   i_color_a,
    input  logic [bc1_pkg::ColorW-1:0]   i_color_b,
    input  logic [bc1_pkg::IdxW-1:0]     i_index_bits,
    output logic                         o_valid,
    input  logic                         i_ready,
    output bc1_pkg::t_ends               o_ends
);
    import bc1_pkg::*;

    logic  r_valid;
    t_ends r_ends;
    t_ends n_ends;
    logic  w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_ends.end_a      = unpack565(i_color_a);
        n_ends.end_b      = unpack565(i_color_b);
        n_ends.four_color = i_color_a > i_color_b;
        n_ends.idx        = i_index_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ends <= n_ends;
        end
    end

    assign o_valid = r_valid;
    assign o_ends  = r_ends;

endmodule

/* rtl/bc1_palette.sv */
// Second pipeline stage: builds the four-entry RGBA palette from the endpoints.
// Depends on bc1_pkg.
module bc1_palette (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bc1_pkg::t_ends  i_ends,
    output logic            o_valid,
    input  logic            i_ready,
    output bc1_pkg::t_pal   o_pal
);
    import bc1_pkg::*;

    logic r_valid;
    t_pal r_pal;
    t_pal n_pal;
    logic w_load;

    function automatic logic [ChanW-1:0] third(input logic [ChanW-1:0] near,
                                               input logic [ChanW-1:0] far);
        logic [9:0] s;
        begin
            s = {1'b0, near, 1'b0} + 10'(far);
            return div3(s);
        end
    endfunction

    function automatic logic [ChanW-1:0] half(input logic [ChanW-1:0] x,
                                              input logic [ChanW-1:0] y);
        logic [ChanW:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            return s[ChanW:1];
        end
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_pal.idx        = i_ends.idx;
        n_pal.entry[0].r = i_ends.end_a.r;
        n_pal.entry[0].g = i_ends.end_a.g;
        n_pal.entry[0].b = i_ends.end_a.b;
        n_pal.entry[0].a = Opaque;
        n_pal.entry[1].r = i_ends.end_b.r;
        n_pal.entry[1].g = i_ends.end_b.g;
        n_pal.entry[1].b = i_ends.end_b.b;
        n_pal.entry[1].a = Opaque;
        if (i_ends.four_color) begin
            n_pal.entry[2].r = third(i_ends.end_a.r, i_ends.end_b.r);
            n_pal.entry[2].g = third(i_ends.end_a.g, i_ends.end_b.g);
            n_pal.entry[2].b = third(i_ends.end_a.b, i_ends.end_b.b);
            n_pal.entry[2].a = Opaque;
            n_pal.entry[3].r = third(i_ends.end_b.r, i_ends.end_a.r);
            n_pal.entry[3].g = third(i_ends.end_b.g, i_ends.end_a.g);
            n_pal.entry[3].b = third(i_ends.end_b.b, i_ends.end_a.b);
            n_pal.entry[3].a = Opaque;
        end else begin
            n_pal.entry[2].r = half(i_ends.end_a.r, i_ends.end_b.r);
            n_pal.entry[2].g = half(i_ends.end_a.g, i_ends.end_b.g);
            n_pal.entry[2].b = half(i_ends.end_a.b, i_ends.end_b.b);
            n_pal.entry[2].a = Opaque;
            n_pal.entry[3].r = Transparent;
            n_pal.entry[3].g = Transparent;
            n_pal.entry[3].b = Transparent;
            n_pal.entry[3].a = Transparent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pal <= n_pal;
        end
    end

    assign o_valid = r_valid;
    assign o_pal   = r_pal;

endmodule

/* rtl/bc1_serialize.sv */
// Third stage and output register: walks the sixteen pixels of one block.
// Depends on bc1_pkg.
module bc1_serialize (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  bc1_pkg::t_pal              i_pal,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bc1_pkg::ChanW-1:0]  o_red,
    output logic [bc1_pkg::ChanW-1:0]  o_green,
    output logic [bc1_pkg::ChanW-1:0]  o_blue,
    output logic [bc1_pkg::ChanW-1:0]  o_alpha,
    output logic [bc1_pkg::PosW-1:0]   o_pixel_col,
    output logic [bc1_pkg::PosW-1:0]   o_pixel_row,
    output logic                       o_last_pixel
);
    import bc1_pkg::*;

    t_pal              r_pal;
    logic              r_busy;
    logic [PixW-1:0]   r_cnt;
    logic              r_out_valid;
    t_rgba             r_pix;
    logic [PixW-1:0]   r_pos;
    logic              r_last;
    logic              w_adv;
    logic              w_emit;
    logic              w_at_last;
    logic              w_load;
    logic [SelW-1:0]   w_sel;

    assign w_adv     = !r_out_valid || i_ready;
    assign w_emit    = r_busy && w_adv;
    assign w_at_last = r_cnt == LastPix;
    assign o_ready   = !r_busy || (w_emit && w_at_last);
    assign w_load    = i_valid && o_ready;
    assign w_sel     = r_pal.idx[{r_cnt, 1'b0} +: SelW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_emit) begin
                if (w_at_last) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pal <= i_pal;
        end
        if (w_emit) begin
            r_pix  <= r_pal.entry[w_sel];
            r_pos  <= r_cnt;
            r_last <= w_at_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red        = r_pix.r;
    assign o_green      = r_pix.g;
    assign o_blue       = r_pix.b;
    assign o_alpha      = r_pix.a;
    assign o_pixel_col  = r_pos[PosW-1:0];
    assign o_pixel_row  = r_pos[PixW-1:PosW];
    assign o_last_pixel = r_last;

endmodule

/* rtl/bc1_block_decoder_core.sv */
// BC1 (DXT1) block decoder. One transfer on the input side carries an 8-byte
// block (two RGB565 endpoints and sixteen 2-bit selectors); the output side then
// gives its sixteen RGBA pixels in row-major order, one per transfer, with column,
// row and a flag on the sixteenth. The sustained rate is set by the single pixel output,
// which delivers one pixel per cycle while the consumer keeps ready high. The first
// pixel of a block is presented after it has passed the endpoint widening stage, the
// palette stage, the pixel walker and the output register. Up to two further blocks
// are held in the stages ahead of the walker, so input transfers continue while
// pixels drain.
module bc1_block_decoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bc1_pkg::ColorW-1:0] i_color_a,
    input  logic [bc1_pkg::ColorW-1:0] i_color_b,
    input  logic [bc1_pkg::IdxW-1:0]   i_index_bits,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bc1_pkg::ChanW-1:0]  o_red,
    output logic [bc1_pkg::ChanW-1:0]  o_green,
    output logic [bc1_pkg::ChanW-1:0]  o_blue,
    output logic [bc1_pkg::ChanW-1:0]  o_alpha,
    output logic [bc1_pkg::PosW-1:0]   o_pixel_col,
    output logic [bc1_pkg::PosW-1:0]   o_pixel_row,
    output logic                       o_last_pixel
);
    import bc1_pkg::*;

    logic  w_ends_valid;
    logic  w_ends_ready;
    t_ends w_ends;
    logic  w_pal_valid;
    logic  w_pal_ready;
    t_pal  w_pal;

    bc1_expand u_expand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_color_a    (i_color_a),
        .i_color_b    (i_color_b),
        .i_index_bits (i_index_bits),
        .o_valid      (w_ends_valid),
        .i_ready      (w_ends_ready),
        .o_ends       (w_ends)
    );

    bc1_palette u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ends_valid),
        .o_ready (w_ends_ready),
        .i_ends  (w_ends),
        .o_valid (w_pal_valid),
        .i_ready (w_pal_ready),
        .o_pal   (w_pal)
    );

    bc1_serialize u_serialize (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_pal_valid),
        .o_ready      (w_pal_ready),
        .i_pal        (w_pal),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_pixel_col  (o_pixel_col),
        .o_pixel_row  (o_pixel_row),
        .o_last_pixel (o_last_pixel)
    );

endmodule

/* rtl/bc1_checker.sv */
// Port-level checker for the BC1 block decoder and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bc1_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    input  logic [1:0] i_pixel_col,
    input  logic [1:0] i_pixel_row,
    input  logic       i_last_pixel
);

    logic [3:0] r_expect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= '0;
        end else if (i_valid && i_ready) begin
            r_expect <= r_expect + 1'b1;
        end
    end

    `ASSERT_RST(a_idle_after_reset, i_clk, !i_rst_n |=> !i_valid, "output valid right after reset")

    `ASSERT_CLK(a_hold_on_stall, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable({i_red, i_green, i_blue, i_alpha, i_pixel_col, i_pixel_row, i_last_pixel}), "stalled pixel changed")

    `ASSERT_CLK(a_pixel_order, i_clk, i_rst_n, i_valid |-> {i_pixel_row, i_pixel_col} == r_expect, "pixel out of row-major order")

    `ASSERT_CLK(a_last_flag, i_clk, i_rst_n, i_valid |-> i_last_pixel == (i_pixel_col == 2'd3 && i_pixel_row == 2'd3), "last flag not on the sixteenth pixel")

    `ASSERT_CLK(a_alpha_code, i_clk, i_rst_n, i_valid |-> (i_alpha == 8'hFF || (i_alpha == 8'h00 && i_red == 8'h00 && i_green == 8'h00 && i_blue == 8'h00)), "bad alpha or non-black transparent pixel")

endmodule

bind bc1_block_decoder_core bc1_checker u_bc1_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_valid),
    .i_ready      (i_ready),
    .i_red        (o_red),
    .i_green      (o_green),
    .i_blue       (o_blue),
    .i_alpha      (o_alpha),
    .i_pixel_col  (o_pixel_col),
    .i_pixel_row  (o_pixel_row),
    .i_last_pixel (o_last_pixel)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bc1_block_decoder_core, the BC1 block to RGBA pixel decoder.
// Depends on bc1_pkg for port widths; predicts each block's sixteen pixels in a local model.
module tb_top;
    import bc1_pkg::*;

    localparam int HoldLen   = 300;
    localparam int DrainWait = 20;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
        logic [PosW-1:0]  col;
        logic [PosW-1:0]  row;
        logic             last;
    } t_pixel;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [ColorW-1:0]  i_color_a;
    logic [ColorW-1:0]  i_color_b;
    logic [IdxW-1:0]    i_index_bits;
    logic               o_valid;
    logic               i_ready;
    logic [ChanW-1:0]   o_red;
    logic [ChanW-1:0]   o_green;
    logic [ChanW-1:0]   o_blue;
    logic [ChanW-1:0]   o_alpha;
    logic [PosW-1:0]    o_pixel_col;
    logic [PosW-1:0]    o_pixel_row;
    logic               o_last_pixel;

    t_pixel      expected_pixels[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned mismatch_count;
    int unsigned blocks_sent;
    int unsigned pixels_checked;

    bc1_block_decoder_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_color_a    (i_color_a),
        .i_color_b    (i_color_b),
        .i_index_bits (i_index_bits),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_pixel_col  (o_pixel_col),
        .o_pixel_row  (o_pixel_row),
        .o_last_pixel (o_last_pixel)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned widen_channel(input int unsigned v, input int unsigned vmax);
        return (v * 255) / vmax;
    endfunction

    task automatic predict_block(input logic [ColorW-1:0] a, input logic [ColorW-1:0] b,
                                 input logic [IdxW-1:0] sel);
        int unsigned pal [4][4];
        int unsigned entry;
        t_pixel      px;
        pal[0][0] = widen_channel(32'(a[15:11]), 31);
        pal[0][1] = widen_channel(32'(a[10:5]), 63);
        pal[0][2] = widen_channel(32'(a[4:0]), 31);
        pal[0][3] = 255;
        pal[1][0] = widen_channel(32'(b[15:11]), 31);
        pal[1][1] = widen_channel(32'(b[10:5]), 63);
        pal[1][2] = widen_channel(32'(b[4:0]), 31);
        pal[1][3] = 255;
        for (int ch = 0; ch < 3; ch++) begin
            if (a > b) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
                pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                pal[3][ch] = 0;
            end
        end
        pal[2][3] = 255;
        pal[3][3] = (a > b) ? 255 : 0;
        for (int n = 0; n < PixPerBlock; n++) begin
            entry    = 32'(sel[2*n +: 2]);
            px.red   = ChanW'(pal[entry][0]);
            px.green = ChanW'(pal[entry][1]);
            px.blue  = ChanW'(pal[entry][2]);
            px.alpha = ChanW'(pal[entry][3]);
            px.col   = PosW'(n % 4);
            px.row   = PosW'(n / 4);
            px.last  = (n == PixPerBlock - 1);
            expected_pixels.push_back(px);
        end
    endtask

    // Called right after a rising edge; returns at the edge where the block is taken.
    task automatic send_block(input logic [ColorW-1:0] a, input logic [ColorW-1:0] b,
                              input logic [IdxW-1:0] sel);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_color_a    <= a;
        i_color_b    <= b;
        i_index_bits <= sel;
        do @(posedge i_clk); while (!o_ready);
        predict_block(a, b, sel);
        blocks_sent++;
    endtask

    task automatic wait_for_pixels();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [ChanW-1:0] got,
                               input logic [ChanW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel %0d %s: got %0d, expected %0d",
                                      pixels_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin : pixel_sink
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel transfer with no block pending");
            end else begin
                want = expected_pixels.pop_front();
                check_field("red", o_red, want.red);
                check_field("green", o_green, want.green);
                check_field("blue", o_blue, want.blue);
                check_field("alpha", o_alpha, want.alpha);
                check_field("column", ChanW'(o_pixel_col), ChanW'(want.col));
                check_field("row", ChanW'(o_pixel_row), ChanW'(want.row));
                check_field("last flag", ChanW'(o_last_pixel), ChanW'(want.last));
                pixels_checked++;
            end
        end
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HoldLen;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_four_color_palette();
        send_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4);
        send_block(16'hF800, 16'h07E0, 32'h00000000);
        send_block(16'h07E0, 16'h001F, 32'hAAAAAAAA);
        send_block(16'h8000, 16'h7FFF, 32'h1B1B1B1B);
        send_block(16'h0001, 16'h0000, 32'hFFFFFFFF);
        send_block(16'hFFFF, 16'hFFFE, 32'h55555555);
    endtask

    task automatic test_three_color_palette();
        send_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4);
        send_block(16'h001F, 16'hF800, 32'hFFFFFFFF);
        send_block(16'h0000, 16'h0001, 32'hAAAAAAAA);
        send_block(16'h7FFF, 16'h8000, 32'h1B1B1B1B);
        send_block(16'h07E0, 16'hF81F, 32'h55555555);
    endtask

    task automatic test_equal_endpoints();
        send_block(16'h0000, 16'h0000, 32'hFFFFFFFF);
        send_block(16'hFFFF, 16'hFFFF, 32'hE4E4E4E4);
        send_block(16'h1234, 16'h1234, 32'h1B1B1B1B);
        send_block(16'hA5C3, 16'hA5C3, 32'h00000000);
    endtask

    task automatic test_random_blocks(input int count);
        logic [ColorW-1:0] a;
        logic [ColorW-1:0] b;
        for (int k = 0; k < count; k++) begin
            a = ColorW'($urandom_range(16'hFFFF));
            b = ColorW'($urandom_range(16'hFFFF));
            if ($urandom_range(7) == 0)
                b = a;
            send_block(a, b, $urandom);
        end
    endtask

    // The sink stops taking pixels while blocks keep coming, so the input side must stall.
    task automatic test_output_stall();
        send_idle_pct = 0;
        hold_req <= hold_req + 1;
        for (int k = 0; k < 10; k++)
            send_block(ColorW'($urandom_range(16'hFFFF)), ColorW'($urandom_range(16'hFFFF)),
                       $urandom);
        wait_for_pixels();
        @(posedge i_clk);
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_color_a      = '0;
        i_color_b      = '0;
        i_index_bits   = '0;
        send_idle_pct  = 34;
        recv_idle_pct  = 73;
        hold_req       = 0;
        hold_seen      = 0;
        hold_left      = 0;
        mismatch_count = 0;
        blocks_sent    = 0;
        pixels_checked = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_four_color_palette();
        test_three_color_palette();
        test_equal_endpoints();
        test_random_blocks(30);
        send_idle_pct = 73;
        recv_idle_pct = 34;
        test_random_blocks(30);
        test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_blocks(25);

        wait_for_pixels();
        repeat (DrainWait) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      expected_pixels.size()));
        $display("Decoded %0d blocks into %0d checked pixels.", blocks_sent, pixels_checked);
        $display("Covered four-color, three-color and equal-endpoint palettes under stalls.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout: run did not finish in time");
        $display("Mismatches found");
        $finish;
    end

endmodule
